@@ design/sdtf_pkg.sv @@
// shared types, constants and helpers of the stereo dual-tap flanger
package sdtf_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned DLY_W      = 20;
  localparam int unsigned ACC_W      = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_PAN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FB    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZEN   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ZLEN  = 4'd7;

  typedef enum logic [4:0] {
    SP_NONE,
    SP_RD_LINE,
    SP_CROSS0,
    SP_CROSS1,
    SP_VIN,
    SP_VFB,
    SP_LP_PREV,
    SP_LP_IN,
    SP_WRITE,
    SP_TA_RD0,
    SP_TA_RD1,
    SP_TA_BASE,
    SP_TA_FRAC,
    SP_TB_BASE,
    SP_TB_FRAC,
    SP_DRY,
    SP_WET,
    SP_ZERO,
    SP_FIN
  } step_e;

  typedef struct packed {
    step_e step;
    logic  capture;
    logic  clearing;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/sdtf_in_if.sv @@
// input sample channel: stereo pair and four tap delays
interface sdtf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic        [19:0] left_delay_a;
  logic        [19:0] left_delay_b;
  logic        [19:0] right_delay_a;
  logic        [19:0] right_delay_b;

  modport source (output valid, left_sample, right_sample, left_delay_a, left_delay_b,
                  right_delay_a, right_delay_b, input ready);
  modport sink (input valid, left_sample, right_sample, left_delay_a, left_delay_b,
                right_delay_a, right_delay_b, output ready);
endinterface

@@ design/sdtf_out_if.sv @@
// output sample channel: stereo pair
interface sdtf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

@@ design/sdtf_cfg_if.sv @@
// configuration write channel
interface sdtf_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ design/sdtf_line_ram.sv @@
// single-port delay line memory with registered read
module sdtf_line_ram #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic signed [15:0]       wdata_i,
  output logic signed [15:0]       rdata_o
);

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sdtf_ctrl.sv @@
// sequencer: memory clear, step sequence and output handshake
module sdtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sdtf_pkg::dp_sts_t sts_i,
  output sdtf_pkg::dp_cmd_t cmd_o
);
  import sdtf_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e state_q;
  step_e  step_q;
  logic   out_valid_q;
  logic   fire;

  assign fire        = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.capture  = in_ready_o && in_valid_i;
    cmd_o.clearing = (state_q == S_CLEAR);
    if (state_q == S_RUN) begin
      cmd_o.step = step_q;
    end else if (state_q == S_DONE && fire) begin
      cmd_o.step = SP_FIN;
    end else begin
      cmd_o.step = SP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= SP_RD_LINE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN;
            step_q  <= SP_RD_LINE;
          end
        end
        S_RUN: begin
          if (step_q == SP_ZERO) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_e'(step_q + 5'd1);
          end
        end
        S_DONE: begin
          if (fire) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/sdtf_dp.sv @@
// datapath: settings, pointers, delay lines and one multiply-accumulate lane per channel
module sdtf_dp #(
  parameter int unsigned DELAY_DEPTH     = 4096,
  parameter int unsigned DELAY_FRAC_BITS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  sdtf_pkg::dp_cmd_t                       cmd_i,
  output sdtf_pkg::dp_sts_t                       sts_o,
  input  logic                                    cfg_we_i,
  input  logic [sdtf_pkg::CFG_IDX_W-1:0]          cfg_addr_i,
  input  logic [sdtf_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [sdtf_pkg::SMP_W-1:0]       left_sample_i,
  input  logic signed [sdtf_pkg::SMP_W-1:0]       right_sample_i,
  input  logic [sdtf_pkg::DLY_W-1:0]              left_delay_a_i,
  input  logic [sdtf_pkg::DLY_W-1:0]              left_delay_b_i,
  input  logic [sdtf_pkg::DLY_W-1:0]              right_delay_a_i,
  input  logic [sdtf_pkg::DLY_W-1:0]              right_delay_b_i,
  output logic signed [sdtf_pkg::SMP_W-1:0]       left_out_o,
  output logic signed [sdtf_pkg::SMP_W-1:0]       right_out_o
);
  import sdtf_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned SW = AW + DLY_W;
  localparam int unsigned FB = DELAY_FRAC_BITS;
  localparam logic signed [18:0] FONE = 19'(1 << FB);
  localparam logic [16:0] ZMAX = 17'(DELAY_DEPTH - 1);

  // settings
  logic signed [7:0]  pan_q;
  logic [15:0]        cross_q;
  logic signed [15:0] fb_q;
  logic [14:0]        damp_q;
  logic [15:0]        dry_q;
  logic               sub_q;
  logic               zen_q;
  logic [11:0]        zlen_q;

  logic [AW-1:0] ptr_q, zptr_q, clr_cnt_q;

  logic signed [SMP_W-1:0] x_q [2];
  logic [DLY_W-1:0]        dly_q [2][2];
  logic signed [SMP_W-1:0] line_rd [2];
  logic signed [SMP_W-1:0] zero_rd [2];
  logic signed [SMP_W-1:0] lane_out [2];

  // derived coefficients
  logic [16:0]        c17, cc17, dry17, wet17;
  logic [15:0]        dm;
  logic signed [7:0]  pan_c, lpan, rpan;
  logic signed [16:0] nfb;
  logic [17:0]        w2;
  logic signed [18:0] wz, wtap, dry4;
  logic [16:0]        zl_c;

  always_comb begin
    c17   = (cross_q > 16'd32768) ? 17'd32768 : {1'b0, cross_q};
    cc17  = 17'd32768 - c17;
    dry17 = (dry_q > 16'd32768) ? 17'd32768 : {1'b0, dry_q};
    wet17 = 17'd32768 - dry17;
    dm    = 16'd32768 - {1'b0, damp_q};
    if (pan_q < -8'sd64) begin
      pan_c = -8'sd64;
    end else if (pan_q > 8'sd64) begin
      pan_c = 8'sd64;
    end else begin
      pan_c = pan_q;
    end
    lpan = (pan_c < 8'sd0) ? 8'sd64 : 8'sd64 - pan_c;
    rpan = (pan_c < 8'sd0) ? 8'sd64 + pan_c : 8'sd64;
    nfb  = -$signed({fb_q[15], fb_q});
    w2   = {wet17, 1'b0};
    wz   = sub_q ? -$signed({1'b0, w2}) : $signed({1'b0, w2});
    wtap = zen_q ? $signed({2'b00, wet17}) : wz;
    dry4 = $signed({dry17, 2'b00});
    zl_c = ({5'd0, zlen_q} > ZMAX) ? ZMAX : {5'd0, zlen_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q   <= 8'sd0;
      cross_q <= 16'd0;
      fb_q    <= -16'sd13717;
      damp_q  <= 15'd4035;
      dry_q   <= 16'd8256;
      sub_q   <= 1'b1;
      zen_q   <= 1'b0;
      zlen_q  <= 12'd105;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PAN:   pan_q   <= cfg_data_i[7:0];
        CFG_CROSS: cross_q <= cfg_data_i;
        CFG_FB:    fb_q    <= cfg_data_i;
        CFG_DAMP:  damp_q  <= cfg_data_i[14:0];
        CFG_DRY:   dry_q   <= cfg_data_i;
        CFG_SUB:   sub_q   <= cfg_data_i[0];
        CFG_ZEN:   zen_q   <= cfg_data_i[0];
        CFG_ZLEN:  zlen_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      zptr_q    <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.clearing) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.step == SP_FIN) begin
        ptr_q <= ptr_q - AW'(1);
        if (zen_q) begin
          zptr_q <= (zptr_q == '0) ? zl_c[AW-1:0] : zptr_q - AW'(1);
        end
      end
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == AW'(DELAY_DEPTH - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q[0]    <= left_sample_i;
      x_q[1]    <= right_sample_i;
      dly_q[0][0] <= left_delay_a_i;
      dly_q[0][1] <= left_delay_b_i;
      dly_q[1][0] <= right_delay_a_i;
      dly_q[1][1] <= right_delay_b_i;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam int unsigned O = 1 - l;

    logic signed [ACC_W-1:0] acc_q, acc_d, r15, rfr, r17;
    logic signed [17:0]      hold_q, op_a;
    logic signed [18:0]      op_b, pan512;
    logic signed [36:0]      prod;
    logic signed [16:0]      diff_q, diff_d;
    logic signed [15:0]      tap0_q, tap1_q, prev_q, out_q, y, x;
    logic                    mac_en, mac_clr;
    logic [DLY_W-1:0]        dly_a, dly_b;
    logic [SW-1:0]           sum_a, sum_b;
    logic [AW-1:0]           t0a, t1a, t0b, t1b, line_addr, zero_addr;
    logic                    line_we, line_re, zero_we, zero_re;
    logic signed [15:0]      line_wd, zero_wd;

    assign x      = x_q[l];
    assign dly_a  = dly_q[l][0];
    assign dly_b  = dly_q[l][1];
    assign pan512 = $signed({3'b000, (l == 0) ? lpan[6:0] : rpan[6:0], 9'd0});
    assign sum_a  = SW'(ptr_q) + SW'(dly_a >> FB);
    assign sum_b  = SW'(ptr_q) + SW'(dly_b >> FB);
    assign t0a    = sum_a[AW-1:0];
    assign t1a    = t0a + AW'(1);
    assign t0b    = sum_b[AW-1:0];
    assign t1b    = t0b + AW'(1);

    assign r15 = (acc_q + 40'sd16384) >>> 15;
    assign rfr = (acc_q + (40'sd1 <<< (FB - 1))) >>> FB;
    assign r17 = (acc_q + 40'sd65536) >>> 17;
    assign y   = sat16(r15);

    always_comb begin
      op_a    = '0;
      op_b    = '0;
      mac_en  = 1'b0;
      mac_clr = 1'b0;
      case (cmd_i.step)
        SP_CROSS0: begin
          mac_en = 1'b1; mac_clr = 1'b1;
          op_a = {{2{line_rd[l][15]}}, line_rd[l]};
          op_b = {2'b00, c17};
        end
        SP_CROSS1: begin
          mac_en = 1'b1;
          op_a = {{2{line_rd[O][15]}}, line_rd[O]};
          op_b = {2'b00, cc17};
        end
        SP_VIN: begin
          mac_en = 1'b1; mac_clr = 1'b1;
          op_a = {{2{x[15]}}, x};
          op_b = pan512;
        end
        SP_VFB: begin
          mac_en = 1'b1;
          op_a = hold_q;
          op_b = {{2{nfb[16]}}, nfb};
        end
        SP_LP_PREV: begin
          mac_en = 1'b1; mac_clr = 1'b1;
          op_a = {{2{prev_q[15]}}, prev_q};
          op_b = {4'b0000, damp_q};
        end
        SP_LP_IN: begin
          mac_en = 1'b1;
          op_a = hold_q;
          op_b = {3'b000, dm};
        end
        SP_TA_BASE, SP_TB_BASE: begin
          mac_en = 1'b1; mac_clr = 1'b1;
          op_a = {{2{line_rd[l][15]}}, line_rd[l]};
          op_b = FONE;
        end
        SP_TA_FRAC: begin
          mac_en = 1'b1;
          op_a = 18'(dly_a[FB-1:0]);
          op_b = {{2{diff_q[16]}}, diff_q};
        end
        SP_TB_FRAC: begin
          mac_en = 1'b1;
          op_a = 18'(dly_b[FB-1:0]);
          op_b = {{2{diff_q[16]}}, diff_q};
        end
        SP_DRY: begin
          mac_en = 1'b1; mac_clr = 1'b1;
          op_a = {{2{x[15]}}, x};
          op_b = dry4;
        end
        SP_WET: begin
          mac_en = 1'b1;
          op_a = {{2{tap0_q[15]}}, tap0_q} + {{2{tap1_q[15]}}, tap1_q};
          op_b = wtap;
        end
        SP_ZERO: begin
          mac_en = 1'b1;
          op_a = zen_q ? {{2{zero_rd[l][15]}}, zero_rd[l]} : 18'sd0;
          op_b = wz;
        end
        default: ;
      endcase
    end

    assign prod   = op_a * op_b;
    assign acc_d  = (mac_clr ? '0 : acc_q) + {{3{prod[36]}}, prod};
    assign diff_d = {line_rd[l][15], line_rd[l]} -
                    ((cmd_i.step == SP_TA_RD1) ? {tap0_q[15], tap0_q} : {tap1_q[15], tap1_q});

    always_ff @(posedge clk_i) begin
      if (mac_en) begin
        acc_q <= acc_d;
      end
      if (cmd_i.step == SP_VIN || cmd_i.step == SP_LP_PREV) begin
        hold_q <= r15[17:0];
      end
      if (cmd_i.step == SP_TA_RD1 || cmd_i.step == SP_TA_FRAC) begin
        diff_q <= diff_d;
      end
      if (cmd_i.step == SP_FIN) begin
        out_q <= sat16(r17);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tap0_q <= '0;
        tap1_q <= '0;
        prev_q <= '0;
      end else begin
        if (cmd_i.step == SP_WRITE) begin
          prev_q <= y;
        end
        if (cmd_i.step == SP_TB_BASE) begin
          tap0_q <= sat16(rfr);
        end
        if (cmd_i.step == SP_DRY) begin
          tap1_q <= sat16(rfr);
        end
      end
    end

    // delay line port
    always_comb begin
      line_we = cmd_i.clearing || (cmd_i.step == SP_WRITE);
      line_wd = cmd_i.clearing ? 16'sd0 : y;
      line_re = (cmd_i.step == SP_RD_LINE) || (cmd_i.step == SP_TA_RD0) ||
                (cmd_i.step == SP_TA_RD1) || (cmd_i.step == SP_TA_BASE) ||
                (cmd_i.step == SP_TA_FRAC);
      if (cmd_i.clearing) begin
        line_addr = clr_cnt_q;
      end else begin
        case (cmd_i.step)
          SP_TA_RD0:  line_addr = t0a;
          SP_TA_RD1:  line_addr = t1a;
          SP_TA_BASE: line_addr = t0b;
          SP_TA_FRAC: line_addr = t1b;
          default:    line_addr = ptr_q;
        endcase
      end
      zero_we   = cmd_i.clearing || (zen_q && cmd_i.step == SP_CROSS0);
      zero_wd   = cmd_i.clearing ? 16'sd0 : x;
      zero_re   = (cmd_i.step == SP_RD_LINE);
      zero_addr = cmd_i.clearing ? clr_cnt_q : zptr_q;
    end

    sdtf_line_ram #(.DEPTH(DELAY_DEPTH)) u_line (
      .clk_i   (clk_i),
      .we_i    (line_we),
      .re_i    (line_re),
      .addr_i  (line_addr),
      .wdata_i (line_wd),
      .rdata_o (line_rd[l])
    );

    sdtf_line_ram #(.DEPTH(DELAY_DEPTH)) u_zero (
      .clk_i   (clk_i),
      .we_i    (zero_we),
      .re_i    (zero_re),
      .addr_i  (zero_addr),
      .wdata_i (zero_wd),
      .rdata_o (zero_rd[l])
    );

    assign lane_out[l] = out_q;
  end

  assign left_out_o  = lane_out[0];
  assign right_out_o = lane_out[1];

endmodule

@@ design/stereo_dual_tap_flanger_core.sv @@
// top level of the stereo dual-tap flanger
// sample_i takes one beat per stereo pair with its four tap delays (DELAY_FRAC_BITS
// fraction bits); result_o gives one stereo beat per accepted input beat, in order.
// cfg_i writes one setting per beat at index addr; it is always ready. Settings are to
// be changed only while the block is idle; the block itself does not enforce this.
// after reset the four delay lines are cleared one entry per cycle; sample_i.ready
// stays low until the last entry has been cleared.
// one item runs through 17 sequencer steps on a single multiply-accumulate unit per
// channel and single-port line memories (four tap reads per line memory set the step
// count), then a final step loads the output register and raises result_o.valid; a new
// input beat is taken only in the idle state, so each item is finished before the next
// is taken.
// the output register lets the next item start while a result waits; if result_o is
// still stalled when that item ends, it holds in its last step until the beat leaves.
module stereo_dual_tap_flanger_core #(
  parameter int unsigned DELAY_DEPTH     = 4096,
  parameter int unsigned DELAY_FRAC_BITS = 8
) (
  input logic         clk_i,
  input logic         rst_ni,
  sdtf_in_if.sink     sample_i,
  sdtf_out_if.source  result_o,
  sdtf_cfg_if.sink    cfg_i
);
  import sdtf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  sdtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdtf_dp #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_i.valid),
    .cfg_addr_i      (cfg_i.addr),
    .cfg_data_i      (cfg_i.data),
    .left_sample_i   (sample_i.left_sample),
    .right_sample_i  (sample_i.right_sample),
    .left_delay_a_i  (sample_i.left_delay_a),
    .left_delay_b_i  (sample_i.left_delay_b),
    .right_delay_a_i (sample_i.right_delay_a),
    .right_delay_b_i (sample_i.right_delay_b),
    .left_out_o      (result_o.left_out),
    .right_out_o     (result_o.right_out)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench of the stereo dual-tap flanger core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdtf_pkg::*;

  localparam int DEPTH = 4096;
  localparam int FRAC  = 8;

  typedef struct packed {
    logic signed [15:0] left_s;
    logic signed [15:0] right_s;
    logic [19:0] ldly_a;
    logic [19:0] ldly_b;
    logic [19:0] rdly_a;
    logic [19:0] rdly_b;
  } pair_t;

  typedef struct packed {
    logic signed [15:0] left_o;
    logic signed [15:0] right_o;
  } stereo_t;

  typedef struct {
    pair_t   beat;
    bit      known;
    stereo_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sdtf_in_if  smp_if ();
  sdtf_out_if res_if ();
  sdtf_cfg_if cfg_if ();

  stereo_dual_tap_flanger_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(smp_if.sink),
    .result_o(res_if.source),
    .cfg_i   (cfg_if.sink)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic signed [15:0] ln_l [DEPTH];
  logic signed [15:0] ln_r [DEPTH];
  logic signed [15:0] zl_l [DEPTH];
  logic signed [15:0] zl_r [DEPTH];
  int unsigned wr_ptr, z_ptr;
  logic signed [15:0] lp_l, lp_r;
  logic signed [15:0] ap [4];
  logic [15:0] reg_val [16];

  stereo_t expected_q [$];
  bit      failed;
  int      send_idle, recv_idle;
  bit      hold_off;

  function automatic longint rnd(longint x, int n);
    longint y;
    y = x + (longint'(1) <<< (n - 1));
    return y >>> n;
  endfunction

  function automatic longint clip16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic logic signed [15:0] interp_tap(bit right, logic [19:0] dly,
                                                    logic signed [15:0] prev);
    int unsigned t0, t1;
    longint f, a, b;
    f  = dly & ((1 << FRAC) - 1);
    t0 = (wr_ptr + (dly >> FRAC)) % DEPTH;
    t1 = (t0 + 1 == DEPTH) ? 0 : t0 + 1;
    a  = right ? ln_r[t0] : ln_l[t0];
    b  = right ? ln_r[t1] : ln_l[t1];
    return 16'(clip16(b + rnd(f * (a - longint'(prev)), FRAC)));
  endfunction

  function automatic stereo_t flange(pair_t it);
    longint p, c, fb, d, dry, wet, sg, lpan, rpan, ld, rd, ml, mr, vl, vr;
    longint xl, xr, zl, zr, sl, sr, al, ar;
    int unsigned zlen;
    stereo_t r;
    xl  = it.left_s;
    xr  = it.right_s;
    p   = $signed(reg_val[CFG_PAN][7:0]);
    c   = reg_val[CFG_CROSS] > 32768 ? 32768 : reg_val[CFG_CROSS];
    fb  = $signed(reg_val[CFG_FB]);
    d   = reg_val[CFG_DAMP][14:0];
    dry = reg_val[CFG_DRY] > 32768 ? 32768 : reg_val[CFG_DRY];
    wet = 32768 - dry;
    sg  = reg_val[CFG_SUB][0] ? -1 : 1;
    zl  = 0;
    zr  = 0;
    if (p < -64) p = -64;
    if (p > 64) p = 64;
    lpan = (p < 0) ? 64 : 64 - p;
    rpan = (p < 0) ? 64 + p : 64;
    ld = ln_l[wr_ptr];
    rd = ln_r[wr_ptr];
    ml = rnd(ld * c + rd * (32768 - c), 15);
    mr = rnd(rd * c + ld * (32768 - c), 15);
    vl = rnd(xl * lpan * 512 - ml * fb, 15);
    vr = rnd(xr * rpan * 512 - mr * fb, 15);
    lp_l = 16'(clip16(rnd(vl * (32768 - d) + longint'(lp_l) * d, 15)));
    lp_r = 16'(clip16(rnd(vr * (32768 - d) + longint'(lp_r) * d, 15)));
    ln_l[wr_ptr] = lp_l;
    ln_r[wr_ptr] = lp_r;
    if (reg_val[CFG_ZEN][0]) begin
      zlen = reg_val[CFG_ZLEN][11:0];
      if (zlen > DEPTH - 1) zlen = DEPTH - 1;
      zl = zl_l[z_ptr];
      zr = zl_r[z_ptr];
      zl_l[z_ptr] = it.left_s;
      zl_r[z_ptr] = it.right_s;
      z_ptr = (z_ptr == 0) ? zlen : z_ptr - 1;
    end
    ap[2] = interp_tap(1, it.rdly_a, ap[2]);
    ap[3] = interp_tap(1, it.rdly_b, ap[3]);
    ap[0] = interp_tap(0, it.ldly_a, ap[0]);
    ap[1] = interp_tap(0, it.ldly_b, ap[1]);
    sl = longint'(ap[0]) + ap[1];
    sr = longint'(ap[2]) + ap[3];
    if (reg_val[CFG_ZEN][0]) begin
      al = 4 * dry * xl + wet * sl + 2 * sg * wet * zl;
      ar = 4 * dry * xr + wet * sr + 2 * sg * wet * zr;
    end else begin
      al = 4 * dry * xl + 2 * sg * wet * sl;
      ar = 4 * dry * xr + 2 * sg * wet * sr;
    end
    r.left_o  = 16'(clip16(rnd(al, 17)));
    r.right_o = 16'(clip16(rnd(ar, 17)));
    wr_ptr = (wr_ptr == 0) ? DEPTH - 1 : wr_ptr - 1;
    return r;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx < 8) reg_val[idx] = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send(pair_t it, bit known, stereo_t want);
    stereo_t p;
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk_i);
    smp_if.valid         <= 1'b1;
    smp_if.left_sample   <= it.left_s;
    smp_if.right_sample  <= it.right_s;
    smp_if.left_delay_a  <= it.ldly_a;
    smp_if.left_delay_b  <= it.ldly_b;
    smp_if.right_delay_a <= it.rdly_a;
    smp_if.right_delay_b <= it.rdly_b;
    do @(posedge clk_i); while (!smp_if.ready);
    p = flange(it);
    if (known && p != want) begin
      $display("%0t table row disagrees: expected %h actual %h", $time, want, p);
      failed = 1'b1;
    end
    expected_q.push_back(p);
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [19:0] rand_delay();
    case ($urandom_range(3))
      0: return 20'($urandom_range(20'hFFFFF));
      1: return 20'($urandom_range(64 << FRAC));
      default: return 20'($urandom_range(1200 << FRAC));
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t it;
    it.left_s  = 16'($urandom);
    it.right_s = 16'($urandom);
    if ($urandom_range(3) == 0) it.left_s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    it.ldly_a = rand_delay();
    it.ldly_b = rand_delay();
    it.rdly_a = rand_delay();
    it.rdly_b = rand_delay();
    return it;
  endfunction

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    stereo_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.left_o  = res_if.left_out;
      got.right_o = res_if.right_out;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        if (got.left_o !== want.left_o) begin
          $display("%0t left_out: expected %0d actual %0d", $time, want.left_o, got.left_o);
          failed = 1'b1;
        end
        if (got.right_o !== want.right_o) begin
          $display("%0t right_out: expected %0d actual %0d", $time, want.right_o,
                   got.right_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t rw;
    stereo_t none;
    int n;
    none = '0;
    failed = 1'b0;
    hold_off = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    smp_if.valid = 1'b0;
    smp_if.left_sample = '0;
    smp_if.right_sample = '0;
    smp_if.left_delay_a = '0;
    smp_if.left_delay_b = '0;
    smp_if.right_delay_a = '0;
    smp_if.right_delay_b = '0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      ln_l[i] = 0; ln_r[i] = 0; zl_l[i] = 0; zl_r[i] = 0;
    end
    for (int i = 0; i < 4; i++) ap[i] = 0;
    for (int i = 0; i < 16; i++) reg_val[i] = '0;
    wr_ptr = 0; z_ptr = 0; lp_l = 0; lp_r = 0;
    reg_val[CFG_PAN]   = 16'd0;
    reg_val[CFG_CROSS] = 16'd0;
    reg_val[CFG_FB]    = 16'(-13717);
    reg_val[CFG_DAMP]  = 16'd4035;
    reg_val[CFG_DRY]   = 16'd8256;
    reg_val[CFG_SUB]   = 16'd1;
    reg_val[CFG_ZEN]   = 16'd0;
    reg_val[CFG_ZLEN]  = 16'd105;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table: zero after reset is known, the rest follows the predictor
    rw.beat = '0; rw.known = 1; rw.want = none; rows.push_back(rw);
    rw.known = 0;
    rw.beat = {16'sh7fff, 16'sh8000, 20'h0, 20'hFFFFF, 20'h000FF, 20'hFFF00};
    rows.push_back(rw);
    rw.beat = {16'sh8000, 16'sh7fff, 20'hFFFFF, 20'h0, 20'hFFF00, 20'h000FF};
    rows.push_back(rw);
    rw.beat = {16'sh7fff, 16'sh7fff, 20'h00180, 20'h00280, 20'h00380, 20'h00480};
    rows.push_back(rw);
    rw.beat = {16'sh8000, 16'sh8000, 20'h00001, 20'h00101, 20'h0FFFF, 20'h10000};
    rows.push_back(rw);
    rw.beat = {16'h5555, 16'haaaa, 20'h55555, 20'haaaaa, 20'h55555, 20'haaaaa};
    rows.push_back(rw);
    foreach (rows[i]) send(rows[i].beat, rows[i].known, rows[i].want);
    settle();

    // register extremes with random items, cross/dry above range too
    write_reg(CFG_PAN, 16'h00C0);
    write_reg(CFG_CROSS, 16'hFFFF);
    write_reg(CFG_FB, 16'h8000);
    write_reg(CFG_DAMP, 16'h7FFF);
    write_reg(CFG_DRY, 16'hFFFF);
    write_reg(CFG_SUB, 16'h0);
    write_reg(CFG_ZEN, 16'h1);
    write_reg(CFG_ZLEN, 16'hFFFF);
    write_reg(4'd9, 16'h1234);
    for (int i = 0; i < 8; i++) send(rand_pair(), 0, none);
    settle();
    write_reg(CFG_PAN, 16'h0040);
    write_reg(CFG_CROSS, 16'h8000);
    write_reg(CFG_FB, 16'h7FFF);
    write_reg(CFG_DAMP, 16'h0);
    write_reg(CFG_DRY, 16'h0);
    write_reg(CFG_SUB, 16'h1);
    write_reg(CFG_ZLEN, 16'h0);
    for (int i = 0; i < 8; i++) send(rand_pair(), 0, none);
    settle();

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send(rand_pair(), 0, none);
    join

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_reg(CFG_PAN, 16'($urandom_range(255)));
      write_reg(CFG_CROSS, ph == 0 ? 16'h0 : 16'($urandom_range(32768)));
      write_reg(CFG_FB, 16'($urandom));
      write_reg(CFG_DAMP, 16'($urandom_range(32767)));
      write_reg(CFG_DRY, ph == 1 ? 16'h8000 : 16'($urandom_range(32768)));
      write_reg(CFG_SUB, 16'($urandom_range(1)));
      write_reg(CFG_ZEN, 16'(ph % 2));
      write_reg(CFG_ZLEN, ph == 3 ? 16'd4095 : 16'($urandom_range(300)));
      send_idle = (ph < 2) ? 33 : (ph < 4) ? 69 : 0;
      recv_idle = (ph < 2) ? 69 : (ph < 4) ? 33 : 0;
      n = 310;
      for (int i = 0; i < n; i++) send(rand_pair(), 0, none);
    end

    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (!failed) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
